[hw/rtl/kxbs_pkg.sv]
// shared types, constants and helpers for the keyed xor / bit-shift packet cipher
// used by every module under hw/rtl; depends on nothing

package kxbs_pkg;

    // key store
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_BITS      = 8 * MAX_KEY_BYTES;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_POS_W     = 5;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(MAX_KEY_BYTES);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(MAX_KEY_BYTES);

    // shift amounts: bytes move up by 5, so 5 bits carry between bytes
    localparam int SHIFT_UP  = 5;
    localparam int CARRY_W   = 8 - 3;
    localparam int HELD_W    = 8 - SHIFT_UP;
    localparam logic [CARRY_W-1:0] CARRY_INIT = CARRY_W'(3);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd3;
    localparam int CFG_DATA_W = 64;

    // mode codes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } out_word_t;

    // configuration seen by the front
    typedef struct packed {
        logic                 mode;
        logic [KEY_BITS-1:0]  key;
        logic [KEY_LEN_W-1:0] key_length;
    } cfg_t;

    // one queued item: one or two output words, the second always ends the packet
    typedef struct packed {
        logic       two_words;
        out_word_t  first;
        logic [7:0] second_data;
    } q_entry_t;

    function automatic logic [7:0] key_byte(
        input logic [KEY_BITS-1:0]  key,
        input logic [KEY_IDX_W-1:0] idx
    );
        return key[idx*8 +: 8];
    endfunction

endpackage

[hw/rtl/kxbs_front.sv]
// front end: accepts packet words, runs the key stream and the shift carry,
// and pushes finished output words into the queue; depends on kxbs_pkg

module kxbs_front import kxbs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_word,
    input  logic     q_full,
    output logic     q_push,
    output q_entry_t q_entry
);

    logic [KEY_POS_W-1:0] key_pos_reg, key_pos_next;
    logic [CARRY_W-1:0]   carry_reg, carry_next;
    logic [HELD_W-1:0]    held_reg, held_next;
    logic                 in_pkt_reg, in_pkt_next;

    logic                 accept;
    logic                 encrypt;
    logic [KEY_POS_W-1:0] pos_cur;
    logic [CARRY_W-1:0]   carry_cur;
    logic [KEY_LEN_W-1:0] len_eff;
    logic                 wrap;
    logic [7:0]           key_val;
    logic [KEY_POS_W-1:0] pos_adv;
    logic                 use_key;
    logic [7:0]           xored;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign encrypt = (cfg.mode == MODE_ENCRYPT);

    // packet start restarts the key stream and the carry
    assign pos_cur   = in_pkt_reg ? key_pos_reg : '0;
    assign carry_cur = in_pkt_reg ? carry_reg : CARRY_INIT;

    // key stream: past the key length, byte 0 is given once and the position resets
    assign len_eff = (cfg.key_length > KEY_LEN_MAX) ? KEY_LEN_MAX : cfg.key_length;
    assign wrap    = (pos_cur >= len_eff);
    assign key_val = wrap ? key_byte(cfg.key, '0) : key_byte(cfg.key, pos_cur[KEY_IDX_W-1:0]);
    assign pos_adv = wrap ? '0 : pos_cur + KEY_POS_W'(1);

    // decrypt draws no key byte on the first word of a packet
    assign use_key = encrypt || in_pkt_reg;
    assign xored   = s_word.data_in ^ key_val;

    // result words
    always_comb begin
        q_entry = '0;
        if (encrypt) begin
            q_entry.two_words      = s_word.last_in;
            q_entry.first.data_out = {xored[2:0], carry_cur};
            q_entry.first.last_out = 1'b0;
            q_entry.second_data    = {3'b000, xored[7:3]};
        end else begin
            q_entry.two_words      = 1'b0;
            q_entry.first.data_out = {s_word.data_in[4:0], held_reg} ^ key_val;
            q_entry.first.last_out = s_word.last_in;
            q_entry.second_data    = '0;
        end
    end

    assign q_push = accept && use_key;

    // state update on every accepted word
    always_comb begin
        key_pos_next = key_pos_reg;
        carry_next   = carry_reg;
        held_next    = held_reg;
        in_pkt_next  = in_pkt_reg;
        if (accept) begin
            key_pos_next = use_key ? pos_adv : pos_cur;
            carry_next   = encrypt ? xored[7:3] : carry_cur;
            held_next    = encrypt ? held_reg : s_word.data_in[7:SHIFT_UP];
            in_pkt_next  = !s_word.last_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pos_reg <= '0;
            carry_reg   <= CARRY_INIT;
            held_reg    <= '0;
            in_pkt_reg  <= 1'b0;
        end else begin
            key_pos_reg <= key_pos_next;
            carry_reg   <= carry_next;
            held_reg    <= held_next;
            in_pkt_reg  <= in_pkt_next;
        end
    end

endmodule

[hw/rtl/kxbs_queue.sv]
// short fifo of result entries between the front and the back
// depends on kxbs_pkg for the entry type and depth

module kxbs_queue import kxbs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic     empty
);

    q_entry_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

[hw/rtl/kxbs_back.sv]
// back end: drains queue entries into the output register, one word a cycle while m_ready allows,
// splitting two-word entries; depends on kxbs_pkg

module kxbs_back import kxbs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    input  q_entry_t  q_entry,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic       m_valid_reg, m_valid_next;
    out_word_t  m_word_reg, m_word_next;
    logic       pend_reg, pend_next;
    logic [7:0] pend_data_reg, pend_data_next;
    logic       load;

    // output register free or being taken
    assign load  = !m_valid_reg || m_ready;
    assign q_pop = load && !pend_reg && !q_empty;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;
        if (load) begin
            if (pend_reg) begin
                m_valid_next         = 1'b1;
                m_word_next.data_out = pend_data_reg;
                m_word_next.last_out = 1'b1;
                pend_next            = 1'b0;
            end else if (!q_empty) begin
                m_valid_next   = 1'b1;
                m_word_next    = q_entry.first;
                pend_next      = q_entry.two_words;
                pend_data_next = q_entry.second_data;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_word_reg    <= m_word_next;
        pend_data_reg <= pend_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

`ifndef SYNTH
    a_pend_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> m_valid_reg)
        else $error("second word pending with no first word shown");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_pend_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pend_reg) |-> !m_word_reg.last_out)
        else $error("closing carry word follows a word marked last");
`endif

endmodule

[hw/rtl/keyed_xor_bit_shift_packet_cipher_top.sv]
// keyed xor / bit-shift packet cipher: one word a cycle in, one word a cycle out,
// while the queue has room and m_ready is high; queued on accept, then registered out
// encrypt adds a closing word per packet; a full four-entry queue then stalls the input
// decrypt emits nothing for the first word of a packet
// synchronous active-low reset: mode encrypt, key zero, key length 16, empty queue
// depends on kxbs_pkg, kxbs_front, kxbs_queue, kxbs_back

module keyed_xor_bit_shift_packet_cipher_top import kxbs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_word
);

    logic                  mode_reg;
    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_len_reg;
    cfg_t                  cfg;

    logic     q_push, q_pop, q_full, q_empty;
    q_entry_t q_in, q_out;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_ENCRYPT;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:       mode_reg     <= cfg_wdata[0];
                REG_KEY_LOW:    key_low_reg  <= cfg_wdata;
                REG_KEY_HIGH:   key_high_reg <= cfg_wdata;
                REG_KEY_LENGTH: key_len_reg  <= cfg_wdata[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode       = mode_reg;
    assign cfg.key        = {key_high_reg, key_low_reg};
    assign cfg.key_length = key_len_reg;

    kxbs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    kxbs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    kxbs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_entry (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

[verif/kxbs_stream_checker.sv]
// stream checker for the keyed xor / bit-shift packet cipher: tracks register writes,
// predicts result words per accepted input word, compares against the result channel
// depends on kxbs_pkg

module kxbs_stream_checker import kxbs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_word_t              s_word,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_word_t             m_word,
    input  logic                  drain_done,
    output int                    pending,
    output int                    failures
);

    // register copies
    logic                 mode_r;
    logic [KEY_BITS-1:0]  key_r;
    logic [KEY_LEN_W-1:0] key_len_r;

    // cipher state
    logic [KEY_POS_W-1:0] key_pos;
    logic [7:0]           carry;
    logic [7:0]           held;
    bit                   in_packet;

    out_word_t cipher_words_q[$];
    bit        leftover_checked;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        failures++;
    endtask

    // next key stream byte; at the end of the key byte 0 comes once more without advancing
    function automatic logic [7:0] key_stream_next();
        logic [KEY_POS_W-1:0] len;
        logic [7:0]           k;
        len = (key_len_r > KEY_LEN_MAX) ? KEY_LEN_MAX : key_len_r;
        if (key_pos >= len) begin
            key_pos = '0;
            return key_r[7:0];
        end
        k = key_r[key_pos[3:0]*8 +: 8];
        key_pos = key_pos + 1'b1;
        return k;
    endfunction

    // work out the result words of one accepted input word
    task automatic predict_cipher(input in_word_t w);
        logic [7:0] x;
        logic [7:0] v;
        bit         first;
        first = !in_packet;
        if (first) begin
            key_pos = '0;
            carry   = 8'd3;
        end
        in_packet = 1'b1;
        if (mode_r == MODE_ENCRYPT) begin
            x = w.data_in ^ key_stream_next();
            cipher_words_q.push_back('{data_out: 8'(x << SHIFT_UP) | carry, last_out: 1'b0});
            carry = x >> 3;
            if (w.last_in)
                cipher_words_q.push_back('{data_out: carry, last_out: 1'b1});
        end else begin
            if (!first) begin
                v = (held >> SHIFT_UP) | 8'(w.data_in << 3);
                cipher_words_q.push_back('{data_out: v ^ key_stream_next(),
                                           last_out: w.last_in});
            end
            held = w.data_in;
        end
        if (w.last_in)
            in_packet = 1'b0;
    endtask

    // one process: register writes, input words, then result words
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (!aresetn) begin
            mode_r    = MODE_ENCRYPT;
            key_r     = '0;
            key_len_r = KEY_LEN_RESET;
            key_pos   = '0;
            carry     = 8'd3;
            held      = 8'd0;
            in_packet = 1'b0;
            cipher_words_q.delete();
            leftover_checked = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODE:       mode_r = cfg_wdata[0];
                    REG_KEY_LOW:    key_r[63:0] = cfg_wdata;
                    REG_KEY_HIGH:   key_r[127:64] = cfg_wdata;
                    REG_KEY_LENGTH: key_len_r = cfg_wdata[KEY_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_cipher(s_word);
            if (m_valid && m_ready) begin
                if (cipher_words_q.size() == 0) begin
                    report_mismatch($sformatf("result word %h/%b with nothing expected",
                                              m_word.data_out, m_word.last_out));
                end else begin
                    exp_w = cipher_words_q.pop_front();
                    if (m_word.data_out !== exp_w.data_out)
                        report_mismatch($sformatf("data_out %h, expected %h",
                                                  m_word.data_out, exp_w.data_out));
                    if (m_word.last_out !== exp_w.last_out)
                        report_mismatch($sformatf("last_out %b, expected %b",
                                                  m_word.last_out, exp_w.last_out));
                end
            end
            // words still owed once the stimulus side says it is done
            if (drain_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (cipher_words_q.size() != 0)
                    report_mismatch($sformatf("%0d result words never arrived",
                                              cipher_words_q.size()));
            end
        end
        pending = cipher_words_q.size();
    end

    initial begin
        failures = 0;
        pending  = 0;
    end

endmodule

[verif/testbench.sv]
// top of the packet cipher testbench: clock, reset, register writes, input words,
// result-side back-pressure and verdict; depends on kxbs_pkg, kxbs_stream_checker
// and keyed_xor_bit_shift_packet_cipher_top

module testbench;
    import kxbs_pkg::*;

    localparam int WORDS_PER_PHASE  = 200;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 3000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_word;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_word;

    logic drain_done;
    bit   long_hold;
    int   send_gap_pct;
    int   recv_gap_pct;
    int   pending;
    int   failures;
    int   stall_cycles;

    keyed_xor_bit_shift_packet_cipher_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    kxbs_stream_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .drain_done (drain_done),
        .pending    (pending),
        .failures   (failures)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // watchdog: cycles in a row with no word moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one word, with a random gap first; returns at the falling edge after acceptance
    task automatic push_word(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_word  = '{data_in: data, last_in: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // block idle: every expected word out, then a settling wait
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // per-phase settings: mode alternates, key length hits both ends and out-of-range codes
    task automatic load_settings(input int phase);
        logic [4:0] len;
        case (phase)
            0: len = 5'd1;
            1: len = 5'd16;
            2: len = 5'd0;
            3: len = 5'd31;
            default: begin
                case ($urandom_range(5))
                    0: len = 5'($urandom_range(31, 17));
                    1: len = 5'd0;
                    default: len = 5'($urandom_range(16, 1));
                endcase
            end
        endcase
        write_reg(REG_MODE, (phase % 2 == 0) ? 64'(MODE_ENCRYPT) : 64'(MODE_DECRYPT));
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        write_reg(REG_KEY_LENGTH, 64'(len));
    endtask

    initial begin : stimulus
        int phase;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_MODE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_word       = '0;
        drain_done   = 1'b0;
        long_hold    = 1'b0;
        send_gap_pct = 14;
        recv_gap_pct = 54;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: encrypt, zero key, full length
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'h01, 1'b1);
        // one-byte packet, and key length one so byte 0 repeats
        wait_idle();
        write_reg(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KEY_HIGH, 64'h8877_6655_4433_2211);
        write_reg(REG_KEY_LENGTH, 64'd1);
        push_word(8'h5A, 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hC3, 1'b1);
        // key length zero, then above the key size
        wait_idle();
        write_reg(REG_KEY_LENGTH, 64'd0);
        push_word(8'h12, 1'b0);
        push_word(8'hED, 1'b1);
        wait_idle();
        write_reg(REG_KEY_LENGTH, 64'd31);
        push_word(8'hA5, 1'b0);
        push_word(8'h7E, 1'b1);
        // decrypt: one-byte packet gives nothing, then a short packet
        wait_idle();
        write_reg(REG_MODE, 64'(MODE_DECRYPT));
        write_reg(REG_KEY_LENGTH, 64'd16);
        push_word(8'hFF, 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hAA, 1'b1);
        // mode flipped inside a packet
        push_word(8'h3C, 1'b0);
        push_word(8'hC3, 1'b0);
        wait_idle();
        write_reg(REG_MODE, 64'(MODE_ENCRYPT));
        push_word(8'h99, 1'b0);
        push_word(8'h66, 1'b1);
        // key length lowered inside a packet
        push_word(8'h01, 1'b0);
        push_word(8'h02, 1'b0);
        push_word(8'h04, 1'b0);
        push_word(8'h08, 1'b0);
        wait_idle();
        write_reg(REG_KEY_LENGTH, 64'd2);
        push_word(8'h10, 1'b1);

        // random packets; phase boundaries may fall inside a packet
        for (phase = 0; phase < 9; phase++) begin
            wait_idle();
            case (phase / 3)
                0: begin send_gap_pct = 14; recv_gap_pct = 54; end
                1: begin send_gap_pct = 54; recv_gap_pct = 14; end
                default: begin send_gap_pct = 0; recv_gap_pct = 0; end
            endcase
            load_settings(phase);
            if (phase == 7)
                long_hold = 1'b1;
            repeat (WORDS_PER_PHASE)
                push_word(8'($urandom_range(255)), ($urandom_range(99) < 12));
        end

        // drain and verdict
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        drain_done = 1'b1;
        repeat (2) @(negedge aclk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
